>>> rtl/core/tpoc_pkg.sv
// Types and constants shared by the timed power output controller.
// Holds the transaction structs, event and report codes, register indexes
// and timer constants. No dependencies.
package tpoc_pkg;

  // Input transaction: one bus event or one-second tick
  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  group_id;
    logic        wake_kind;
    logic [15:0] wake_seconds;
  } tpoc_in_t;

  // Output transaction: state report, query reply or wake details reply
  typedef struct packed {
    logic [1:0]  report_kind;
    logic [7:0]  report_group;
    logic        output_on;
    logic        pin_level;
    logic        relay_pulse;
    logic [7:0]  minutes_left;
    logic [15:0] seconds_left;
  } tpoc_out_t;

  // Event codes
  localparam logic [2:0] MODE_TICK        = 3'd0;
  localparam logic [2:0] MODE_BUTTON_DOWN = 3'd1;
  localparam logic [2:0] MODE_GROUP_ON    = 3'd2;
  localparam logic [2:0] MODE_GROUP_OFF   = 3'd3;
  localparam logic [2:0] MODE_QUERY       = 3'd4;
  localparam logic [2:0] MODE_WAKE_SET    = 3'd5;
  localparam logic [2:0] MODE_WAKE_INFO   = 3'd6;

  // Report codes
  localparam logic [1:0] REPORT_STATE     = 2'd0;
  localparam logic [1:0] REPORT_QUERY     = 2'd1;
  localparam logic [1:0] REPORT_WAKE_INFO = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURE_MODES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIMARY_GROUP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_GROUP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_GROUP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOURTH_GROUP  = 3'd4;

  // Feature mode bits
  localparam int unsigned FM_AUTO_OFF   = 0;
  localparam int unsigned FM_DELAYED_ON = 1;
  localparam int unsigned FM_RUN_ON     = 2;
  localparam int unsigned FM_BISTABLE   = 3;

  localparam logic [7:0] GROUP_NONE = 8'd255;

  // Minutes conversion: x / 60 == (x * MIN_RECIP) >> MIN_SHIFT for x < 2**16
  localparam logic [16:0] MIN_RECIP = 17'd69906;
  localparam int unsigned MIN_SHIFT = 22;
  // At or above this countdown the minutes value saturates
  localparam logic [15:0] MIN_SAT_LIMIT = 16'd15240;
  localparam logic [7:0]  MIN_SAT       = 8'd255;

endpackage

>>> rtl/core/timed_power_output_controller_top.sv
// Timed power output controller, top level.
// Depends on tpoc_pkg for transaction types, codes and constants.
// Contains the event step logic and a two-entry result queue.

// Takes one event per clock. Each accepted event updates the countdown,
// pin and relay state in the same cycle and, where it produces a report,
// places it in a two-entry output queue; with the queue empty the report is
// visible on out_data the cycle after acceptance, otherwise it waits behind
// the reports ahead of it. Sustained rate is one event per cycle, set by
// the single step register stage. in_stall rises only when both queue
// entries hold reports that the downstream side has not yet taken.
// Configuration writes are always ready and take effect on the next event.
module timed_power_output_controller_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tpoc_pkg::tpoc_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tpoc_pkg::tpoc_out_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tpoc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  // Configuration registers
  logic [3:0] feature_modes;
  logic [7:0] primary_group;
  logic [7:0] second_group;
  logic [7:0] third_group;
  logic [7:0] fourth_group_or_time;

  // Controller state
  logic [15:0] countdown;
  logic        pin_state;
  logic        relay_latched;
  logic        wake_on_pending;
  logic        wake_off_pending;

  logic [15:0] countdown_next;
  logic        pin_state_next;
  logic        relay_latched_next;
  logic        wake_on_pending_next;
  logic        wake_off_pending_next;

  // Result queue
  tpoc_pkg::tpoc_out_t q0;
  tpoc_pkg::tpoc_out_t q1;
  logic                v0;
  logic                v1;

  logic                accept;
  logic                pop;
  logic                push;
  tpoc_pkg::tpoc_out_t res;

  logic        timer_modes;
  logic        bistable;
  logic        match;
  logic [15:0] reload_val;
  logic [32:0] min_prod;
  logic [7:0]  mins;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = v1;
  assign out_valid = v0;
  assign out_data  = q0;
  assign pop       = v0 && !out_stall;

  // Decode configuration
  assign timer_modes = |feature_modes[tpoc_pkg::FM_RUN_ON:tpoc_pkg::FM_AUTO_OFF];
  assign bistable    = feature_modes[tpoc_pkg::FM_BISTABLE];

  // Timer reload: seconds when bit 7 is set, else minutes times 60
  assign reload_val = fourth_group_or_time[7]
                    ? {9'd0, fourth_group_or_time[6:0]}
                    : ({2'd0, fourth_group_or_time, 6'd0} - {6'd0, fourth_group_or_time, 2'd0});

  // Group membership
  assign match = (in_data.group_id != tpoc_pkg::GROUP_NONE) &&
                 ((in_data.group_id == primary_group) ||
                  (in_data.group_id == second_group) ||
                  (in_data.group_id == third_group) ||
                  (!timer_modes && in_data.group_id == fourth_group_or_time));

  // Minutes left for a query, saturated
  assign min_prod = {17'd0, countdown} * {16'd0, tpoc_pkg::MIN_RECIP};
  always_comb begin
    if (countdown == 16'd0) begin
      mins = 8'd0;
    end else if (countdown >= tpoc_pkg::MIN_SAT_LIMIT) begin
      mins = tpoc_pkg::MIN_SAT;
    end else begin
      mins = min_prod[tpoc_pkg::MIN_SHIFT +: 8] + 8'd1;
    end
  end

  // Step logic: next state and optional report for the incoming event
  always_comb begin
    logic do_on;
    logic do_off;
    logic pulse;
    logic [15:0] cd_tmp;

    do_on  = 1'b0;
    do_off = 1'b0;
    pulse  = 1'b0;
    cd_tmp = countdown;

    countdown_next        = countdown;
    pin_state_next        = pin_state;
    relay_latched_next    = relay_latched;
    wake_on_pending_next  = wake_on_pending;
    wake_off_pending_next = wake_off_pending;
    push                  = 1'b0;

    res.report_kind  = tpoc_pkg::REPORT_STATE;
    res.report_group = primary_group;
    res.output_on    = 1'b0;
    res.pin_level    = 1'b0;
    res.relay_pulse  = 1'b0;
    res.minutes_left = 8'd0;
    res.seconds_left = 16'd0;

    if (accept) begin
      case (in_data.mode)
        tpoc_pkg::MODE_TICK: begin
          if (countdown == 16'd1) begin
            if (wake_on_pending) begin
              do_on                = 1'b1;
              wake_on_pending_next = 1'b0;
              cd_tmp               = reload_val;
            end else if (wake_off_pending) begin
              do_off                = 1'b1;
              wake_off_pending_next = 1'b0;
            end else if (feature_modes[tpoc_pkg::FM_DELAYED_ON]) begin
              do_on = 1'b1;
            end else if (feature_modes[tpoc_pkg::FM_AUTO_OFF] ||
                         feature_modes[tpoc_pkg::FM_RUN_ON]) begin
              do_off = 1'b1;
            end
          end
          // Count down, never below zero
          if (countdown != 16'd0 && cd_tmp != 16'd0) begin
            countdown_next = cd_tmp - 16'd1;
          end else begin
            countdown_next = cd_tmp;
          end
        end
        tpoc_pkg::MODE_BUTTON_DOWN, tpoc_pkg::MODE_GROUP_ON,
        tpoc_pkg::MODE_GROUP_OFF: begin
          if (match) begin
            if (in_data.mode == tpoc_pkg::MODE_GROUP_OFF ||
                (in_data.mode == tpoc_pkg::MODE_BUTTON_DOWN && pin_state)) begin
              // Falling edge of the group
              if (feature_modes[tpoc_pkg::FM_RUN_ON]) begin
                countdown_next = reload_val;
              end else begin
                do_off         = 1'b1;
                countdown_next = 16'd0;
              end
            end else begin
              // Rising edge of the group
              if (feature_modes[tpoc_pkg::FM_AUTO_OFF]) begin
                do_on          = 1'b1;
                countdown_next = reload_val;
              end else if (feature_modes[tpoc_pkg::FM_DELAYED_ON]) begin
                countdown_next = reload_val;
              end else begin
                do_on          = 1'b1;
                countdown_next = 16'd0;
              end
            end
          end
        end
        tpoc_pkg::MODE_QUERY: begin
          if (match) begin
            push             = 1'b1;
            res.report_kind  = tpoc_pkg::REPORT_QUERY;
            res.report_group = in_data.group_id;
            res.minutes_left = mins;
          end
        end
        tpoc_pkg::MODE_WAKE_SET: begin
          if (match && in_data.group_id == primary_group) begin
            if (in_data.wake_kind) begin
              wake_off_pending_next = 1'b1;
            end else begin
              wake_on_pending_next = 1'b1;
            end
            countdown_next = in_data.wake_seconds;
            if (in_data.wake_kind || wake_off_pending) begin
              do_on = 1'b1;
            end
          end
        end
        tpoc_pkg::MODE_WAKE_INFO: begin
          if (match && in_data.group_id == primary_group) begin
            push             = 1'b1;
            res.report_kind  = tpoc_pkg::REPORT_WAKE_INFO;
            res.seconds_left = countdown;
          end
        end
        default: begin
        end
      endcase
    end

    // Apply switching
    if (do_on) begin
      push = 1'b1;
      if (bistable) begin
        relay_latched_next = !relay_latched;
        pin_state_next     = 1'b0;
        pulse              = 1'b1;
      end else begin
        pin_state_next = 1'b1;
      end
    end else if (do_off) begin
      push           = 1'b1;
      pin_state_next = 1'b0;
    end

    res.relay_pulse = pulse;
    res.pin_level   = pin_state_next;
    res.output_on   = bistable ? relay_latched_next : pin_state_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      feature_modes        <= 4'd0;
      primary_group        <= tpoc_pkg::GROUP_NONE;
      second_group         <= tpoc_pkg::GROUP_NONE;
      third_group          <= tpoc_pkg::GROUP_NONE;
      fourth_group_or_time <= tpoc_pkg::GROUP_NONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tpoc_pkg::REG_FEATURE_MODES: feature_modes        <= cfg_data[3:0];
        tpoc_pkg::REG_PRIMARY_GROUP: primary_group        <= cfg_data;
        tpoc_pkg::REG_SECOND_GROUP:  second_group         <= cfg_data;
        tpoc_pkg::REG_THIRD_GROUP:   third_group          <= cfg_data;
        tpoc_pkg::REG_FOURTH_GROUP:  fourth_group_or_time <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      countdown        <= 16'd0;
      pin_state        <= 1'b0;
      relay_latched    <= 1'b0;
      wake_on_pending  <= 1'b0;
      wake_off_pending <= 1'b0;
    end else begin
      countdown        <= countdown_next;
      pin_state        <= pin_state_next;
      relay_latched    <= relay_latched_next;
      wake_on_pending  <= wake_on_pending_next;
      wake_off_pending <= wake_off_pending_next;
    end
  end

  // Result queue control: push never coincides with a full queue
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (pop && push) begin
        v0 <= 1'b1;
      end else if (pop) begin
        v0 <= v1;
        v1 <= 1'b0;
      end else if (push) begin
        if (v0) begin
          v1 <= 1'b1;
        end else begin
          v0 <= 1'b1;
        end
      end
    end
  end

  // Result queue payload
  always_ff @(posedge clk) begin
    if (pop && push) begin
      q0 <= res;
    end else if (pop) begin
      q0 <= q1;
    end else if (push) begin
      if (v0) begin
        q1 <= res;
      end else begin
        q0 <= res;
      end
    end
  end

  // Second queue entry is only ever filled behind the head
  a_queue_order: assert property (@(posedge clk) disable iff (rst) v1 |-> v0)
    else $error("result queue holds a second entry without a head");

  // A tick on an idle timer leaves it idle
  a_no_wrap: assert property (@(posedge clk) disable iff (rst)
      (accept && in_data.mode == tpoc_pkg::MODE_TICK && countdown == 16'd0)
      |=> countdown == 16'd0)
    else $error("countdown wrapped below zero");

  // A relay pulse report goes with a toggle of the latched relay
  a_pulse_toggle: assert property (@(posedge clk) disable iff (rst)
      (push && res.relay_pulse) |=> relay_latched != $past(relay_latched))
    else $error("relay pulse without relay toggle");

  // Pending wake-on fires and clears when the countdown expires
  a_wake_clear: assert property (@(posedge clk) disable iff (rst)
      (accept && in_data.mode == tpoc_pkg::MODE_TICK && countdown == 16'd1 &&
       wake_on_pending) |=> !wake_on_pending)
    else $error("wake-on pending not cleared on expiry");

endmodule

>>> verif/tpoc_report_checker.sv
// Report checker for the timed power output controller.
// Watches the event, report and register write channels, keeps its own model
// of the controller and compares every report. Depends on tpoc_pkg.
module tpoc_report_checker
  import tpoc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  tpoc_in_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  tpoc_out_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   mismatches,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies
  logic [3:0]  feature_bits;
  logic [7:0]  primary_id;
  logic [7:0]  second_id;
  logic [7:0]  third_id;
  logic [7:0]  fourth_or_time;

  // Controller state
  logic [15:0] seconds_to_go;
  logic        pin_on;
  logic        relay_on;
  logic        wake_on_armed;
  logic        wake_off_armed;

  tpoc_out_t   expected_reports[$];
  tpoc_out_t   oldest_report;

  // Countdown value loaded from the timer byte: seconds if bit 7, else minutes
  function automatic logic [15:0] timer_reload();
    if (fourth_or_time[7])
      return {9'd0, fourth_or_time[6:0]};
    return {8'd0, fourth_or_time} * 16'd60;
  endfunction

  function automatic bit group_hit(input logic [7:0] id);
    if (id == GROUP_NONE)
      return 1'b0;
    if (id == primary_id || id == second_id || id == third_id)
      return 1'b1;
    return (feature_bits[2:0] == 3'b000) && (id == fourth_or_time);
  endfunction

  task automatic queue_report(input logic [1:0] kind, input logic [7:0] id, input logic pulse,
                              input logic [7:0] mins, input logic [15:0] secs);
    tpoc_out_t rpt;
    rpt.report_kind  = kind;
    rpt.report_group = id;
    rpt.output_on    = feature_bits[FM_BISTABLE] ? relay_on : pin_on;
    rpt.pin_level    = pin_on;
    rpt.relay_pulse  = pulse;
    rpt.minutes_left = mins;
    rpt.seconds_left = secs;
    expected_reports.push_back(rpt);
  endtask

  // Switch on: toggle the latched relay with a pulse, or drive the pin high
  task automatic turn_on();
    logic pulse;
    pulse = 1'b0;
    if (feature_bits[FM_BISTABLE]) begin
      relay_on = ~relay_on;
      pin_on   = 1'b0;
      pulse    = 1'b1;
    end else begin
      pin_on = 1'b1;
    end
    queue_report(REPORT_STATE, primary_id, pulse, 8'd0, 16'd0);
  endtask

  task automatic turn_off();
    pin_on = 1'b0;
    queue_report(REPORT_STATE, primary_id, 1'b0, 8'd0, 16'd0);
  endtask

  task automatic group_on_event();
    if (feature_bits[FM_AUTO_OFF]) begin
      turn_on();
      seconds_to_go = timer_reload();
    end else if (feature_bits[FM_DELAYED_ON]) begin
      seconds_to_go = timer_reload();
    end else begin
      turn_on();
      seconds_to_go = 16'd0;
    end
  endtask

  task automatic group_off_event();
    if (feature_bits[FM_RUN_ON]) begin
      seconds_to_go = timer_reload();
    end else begin
      turn_off();
      seconds_to_go = 16'd0;
    end
  endtask

  // One-second tick: act when the countdown is about to expire, then count down
  task automatic tick_event();
    if (seconds_to_go == 16'd1) begin
      if (wake_on_armed) begin
        turn_on();
        wake_on_armed = 1'b0;
        seconds_to_go = timer_reload();
      end else if (wake_off_armed) begin
        turn_off();
        wake_off_armed = 1'b0;
      end else if (feature_bits[FM_DELAYED_ON]) begin
        turn_on();
      end else if (feature_bits[FM_AUTO_OFF] || feature_bits[FM_RUN_ON]) begin
        turn_off();
      end
    end
    if (seconds_to_go != 16'd0)
      seconds_to_go = seconds_to_go - 16'd1;
  endtask

  task automatic apply_event(input tpoc_in_t ev);
    int unsigned mins;
    mins = 0;
    if (ev.mode == MODE_TICK) begin
      tick_event();
    end else if (group_hit(ev.group_id)) begin
      case (ev.mode)
        MODE_BUTTON_DOWN: begin
          if (pin_on)
            group_off_event();
          else
            group_on_event();
        end
        MODE_GROUP_ON: group_on_event();
        MODE_GROUP_OFF: group_off_event();
        MODE_QUERY: begin
          if (seconds_to_go != 16'd0) begin
            mins = seconds_to_go / 60 + 1;
            if (mins > 255)
              mins = 255;
          end
          queue_report(REPORT_QUERY, ev.group_id, 1'b0, 8'(mins), 16'd0);
        end
        MODE_WAKE_SET: begin
          if (ev.group_id == primary_id) begin
            if (ev.wake_kind)
              wake_off_armed = 1'b1;
            else
              wake_on_armed = 1'b1;
            seconds_to_go = ev.wake_seconds;
            if (wake_off_armed)
              turn_on();
          end
        end
        MODE_WAKE_INFO: begin
          if (ev.group_id == primary_id)
            queue_report(REPORT_WAKE_INFO, primary_id, 1'b0, 8'd0, seconds_to_go);
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0d ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Predict on each accepted event, compare each accepted report, track writes
  always @(posedge clk) begin
    if (rst) begin
      feature_bits   = 4'd0;
      primary_id     = 8'd255;
      second_id      = 8'd255;
      third_id       = 8'd255;
      fourth_or_time = 8'd255;
      seconds_to_go  = 16'd0;
      pin_on         = 1'b0;
      relay_on       = 1'b0;
      wake_on_armed  = 1'b0;
      wake_off_armed = 1'b0;
      expected_reports.delete();
    end else begin
      if (in_valid && !in_stall)
        apply_event(in_data);
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          $display("%0d ns: report with none expected, expected nothing, got %h",
                   $time, out_data);
        end else begin
          oldest_report = expected_reports.pop_front();
          check_field("report_kind", 16'(oldest_report.report_kind),
                      16'(out_data.report_kind));
          check_field("report_group", 16'(oldest_report.report_group),
                      16'(out_data.report_group));
          check_field("output_on", 16'(oldest_report.output_on),
                      16'(out_data.output_on));
          check_field("pin_level", 16'(oldest_report.pin_level),
                      16'(out_data.pin_level));
          check_field("relay_pulse", 16'(oldest_report.relay_pulse),
                      16'(out_data.relay_pulse));
          check_field("minutes_left", 16'(oldest_report.minutes_left),
                      16'(out_data.minutes_left));
          check_field("seconds_left", oldest_report.seconds_left, out_data.seconds_left);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FEATURE_MODES: feature_bits   = cfg_data[3:0];
          REG_PRIMARY_GROUP: primary_id     = cfg_data;
          REG_SECOND_GROUP:  second_id      = cfg_data;
          REG_THIRD_GROUP:   third_id       = cfg_data;
          REG_FOURTH_GROUP:  fourth_or_time = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = expected_reports.size();
  end

endmodule

>>> verif/tb_timed_power_output_controller_top.sv
// Testbench top for the timed power output controller.
// Generates clock, reset, events, register writes and random stalls; the
// report checker does prediction and comparison. Depends on tpoc_pkg.
module tb_timed_power_output_controller_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tpoc_pkg::*;

  localparam logic [2:0] MODE_UNUSED     = 3'd7;
  localparam int         IDLE_PCT        = 16;
  localparam int         SETTLE_CYCLES   = 8;
  localparam int         EVENTS_PER_PLAN = 128;
  localparam int         CYCLE_LIMIT     = 400000;
  localparam int         PLAN_COUNT      = 11;

  typedef struct packed {
    logic [3:0] modes;
    logic [7:0] primary;
    logic [7:0] second;
    logic [7:0] third;
    logic [7:0] fourth;
  } setting_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  tpoc_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  tpoc_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FEATURE_MODES;
  logic [7:0]           cfg_data = 8'd0;
  int                   mismatches;
  int                   outstanding;
  int                   cycle_count = 0;
  logic                 quiet = 1'b0;
  setting_t             active;

  // Register settings, extremes included
  setting_t plan [PLAN_COUNT] = '{
    '{4'h0, 8'd1,   8'd2,   8'd3,   8'd4},
    '{4'h1, 8'd10,  8'd20,  8'd30,  8'h85},
    '{4'h2, 8'd10,  8'd20,  8'd30,  8'h83},
    '{4'h4, 8'd40,  8'd41,  8'd42,  8'h84},
    '{4'h8, 8'd0,   8'd254, 8'd255, 8'd7},
    '{4'hF, 8'd0,   8'd255, 8'd255, 8'h80},
    '{4'h3, 8'd128, 8'd127, 8'd1,   8'h01},
    '{4'hC, 8'd200, 8'd201, 8'd202, 8'h00},
    '{4'h5, 8'd255, 8'd9,   8'd99,  8'hFF},
    '{4'h7, 8'd5,   8'd6,   8'd7,   8'h82},
    '{4'hA, 8'd33,  8'd34,  8'd35,  8'h81}
  };

  timed_power_output_controller_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tpoc_report_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stall the report side at random, except during the quiet stretch
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic tpoc_in_t make_event(input logic [2:0] mode, input logic [7:0] id,
                                          input logic kind, input logic [15:0] secs);
    tpoc_in_t ev;
    ev.mode         = mode;
    ev.group_id     = id;
    ev.wake_kind    = kind;
    ev.wake_seconds = secs;
    return ev;
  endfunction

  // Mostly matching groups and short wake times so countdowns expire often
  function automatic tpoc_in_t random_event();
    int         pick;
    logic [2:0] mode;
    logic [7:0] id;
    logic [15:0] secs;
    pick = $urandom_range(99);
    if (pick < 40)      mode = MODE_TICK;
    else if (pick < 50) mode = MODE_BUTTON_DOWN;
    else if (pick < 60) mode = MODE_GROUP_ON;
    else if (pick < 70) mode = MODE_GROUP_OFF;
    else if (pick < 78) mode = MODE_QUERY;
    else if (pick < 88) mode = MODE_WAKE_SET;
    else if (pick < 96) mode = MODE_WAKE_INFO;
    else                mode = MODE_UNUSED;
    pick = $urandom_range(9);
    if (pick < 4)       id = active.primary;
    else if (pick == 4) id = active.second;
    else if (pick == 5) id = active.third;
    else if (pick == 6) id = active.fourth;
    else if (pick == 7) id = GROUP_NONE;
    else                id = 8'($urandom_range(255));
    pick = $urandom_range(9);
    if (pick < 7)       secs = 16'($urandom_range(8));
    else if (pick < 9)  secs = 16'($urandom_range(300));
    else                secs = 16'($urandom_range(65535));
    return make_event(mode, id, 1'($urandom_range(1)), secs);
  endfunction

  // Offer one transaction, idling at random first; hold it until accepted
  task automatic send_event(input tpoc_in_t ev);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every expected report, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_setting(input setting_t s);
    drain();
    active = s;
    write_reg(REG_FEATURE_MODES, {4'd0, s.modes});
    write_reg(REG_PRIMARY_GROUP, s.primary);
    write_reg(REG_SECOND_GROUP, s.second);
    write_reg(REG_THIRD_GROUP, s.third);
    write_reg(REG_FOURTH_GROUP, s.fourth);
  endtask

  initial begin
    active = '{4'h0, 8'd255, 8'd255, 8'd255, 8'd255};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: nothing matches
    send_event(make_event(MODE_TICK, GROUP_NONE, 1'b1, 16'hFFFF));
    send_event(make_event(MODE_GROUP_ON, GROUP_NONE, 1'b0, 16'd0));

    // Directed: plain groups, timer byte four minutes
    load_setting(plan[0]);
    send_event(make_event(MODE_QUERY, 8'd1, 1'b0, 16'd0));
    send_event(make_event(MODE_GROUP_ON, 8'd2, 1'b0, 16'd0));
    send_event(make_event(MODE_GROUP_OFF, 8'd3, 1'b0, 16'd0));
    send_event(make_event(MODE_BUTTON_DOWN, 8'd4, 1'b0, 16'd0));
    send_event(make_event(MODE_BUTTON_DOWN, 8'd4, 1'b0, 16'd0));
    send_event(make_event(MODE_GROUP_ON, GROUP_NONE, 1'b0, 16'd0));
    send_event(make_event(MODE_UNUSED, 8'd1, 1'b1, 16'd5));
    // Wake on a non-primary group is ignored
    send_event(make_event(MODE_WAKE_SET, 8'd2, 1'b1, 16'd2));
    // Wake auto-off: on now, off when the countdown expires, no wrap below zero
    send_event(make_event(MODE_WAKE_SET, 8'd1, 1'b1, 16'd2));
    send_event(make_event(MODE_TICK, 8'd0, 1'b0, 16'd0));
    send_event(make_event(MODE_TICK, 8'd0, 1'b0, 16'd0));
    send_event(make_event(MODE_TICK, 8'd0, 1'b0, 16'd0));
    // Longest countdown: saturated minutes and raw seconds
    send_event(make_event(MODE_WAKE_SET, 8'd1, 1'b0, 16'hFFFF));
    send_event(make_event(MODE_QUERY, 8'd3, 1'b0, 16'd0));
    send_event(make_event(MODE_WAKE_INFO, 8'd1, 1'b0, 16'd0));
    // Wake delayed-on fires and reloads the timer
    send_event(make_event(MODE_WAKE_SET, 8'd1, 1'b0, 16'd1));
    send_event(make_event(MODE_TICK, 8'hFF, 1'b1, 16'hFFFF));
    send_event(make_event(MODE_QUERY, 8'd2, 1'b0, 16'd0));
    send_event(make_event(MODE_GROUP_OFF, 8'd1, 1'b0, 16'd0));
    send_event(make_event(MODE_WAKE_INFO, 8'd1, 1'b0, 16'd0));
    // Wake auto-off with zero seconds
    send_event(make_event(MODE_WAKE_SET, 8'd1, 1'b1, 16'd0));
    send_event(make_event(MODE_TICK, 8'd0, 1'b0, 16'd0));

    // Random phases across all settings; one phase runs without idling
    for (int p = 0; p < PLAN_COUNT; p++) begin
      load_setting(plan[p]);
      quiet <= (p == 3);
      for (int n = 0; n < EVENTS_PER_PLAN; n++)
        send_event(random_event());
    end

    drain();
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> timed_power_output_controller_top.f
rtl/core/tpoc_pkg.sv
rtl/core/timed_power_output_controller_top.sv
verif/tpoc_report_checker.sv
verif/tb_timed_power_output_controller_top.sv
